[hw/rtl/quaternion_to_euler_assert.svh]
// Assertion macros for the quaternion_to_euler block.
// Used by the top level; no other dependencies.
`ifndef QUATERNION_TO_EULER_ASSERT_SVH
`define QUATERNION_TO_EULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QTE_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define QTE_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define QTE_ASSERT_SAME(lbl, ck, rs, ante, cons, msg)
`define QTE_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

[hw/rtl/qte_pkg.sv]
// Shared constants for the quaternion to Euler angle pipeline.
// No dependencies.
package qte_pkg;
  localparam int TW = 35;
  localparam int CW = 38;
  localparam int ROOT_BITS = 31;
  localparam int N_BITS = 61;
  localparam int TAB_LEN = 24;
  localparam int DEF_CORDIC_STAGES = 16;
  localparam logic [31:0] PI_BAM = 32'h8000_0000;
  localparam logic [31:0] ROUND_HALF = 32'h0000_8000;
  localparam logic [31:0] ATAN_TAB [0:TAB_LEN-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };
endpackage

[hw/rtl/quaternion_to_euler.sv]
// Top level: unit quaternion (Q1.15) to yaw, pitch, roll binary angles.
// Depends on qte_pkg, qte_isqrt, qte_cordic, quaternion_to_euler_assert.svh.
//
// Input beat on s_*: one quaternion. Output beat on m_*: yaw, pitch, roll,
// signed 16-bit angles with 32768 = pi; pitch is held to +/-16384.
// The ZYX formulas are applied to the x, y, z and w parts as given.
// Throughput: one beat per cycle while the pipe is not stalled. Stages:
// 3 product/sum stages, 31 square root stages for the pitch cosine,
// CORDIC_STAGES + 2 CORDIC stages, 1 output register.
// All stages but the output register share one enable and carry a valid
// bit; bubbles pass through freely. The pipe only stops when its last
// stage holds a result and the output register still holds an untaken
// beat; s_tready then drops. Nothing is lost or repeated across a stall.
// Reset (rst, synchronous) clears all valid bits; m_tvalid goes low.
// Every input bit pattern is accepted; non-unit inputs are used as given.
module quaternion_to_euler #(
  parameter int CORDIC_STAGES = qte_pkg::DEF_CORDIC_STAGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // q_w, q_x, q_y, q_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // roll_angle, pitch_angle, yaw_angle
);
  import qte_pkg::*;

  localparam logic signed [TW-1:0] ONE_T = TW'(64'sd1 <<< 30);
  localparam logic [63:0] ONE_SQ = 64'd1 << 60;

  typedef struct packed {
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;
    logic signed [TW-1:0] t3;
    logic signed [TW-1:0] t4;
  } ops_t;

  logic ce, out_ld, last_vld;
  logic signed [15:0] qx, qy, qz, qw;

  assign qz = s_tdata[15:0];
  assign qy = s_tdata[31:16];
  assign qx = s_tdata[47:32];
  assign qw = s_tdata[63:48];

  // stage 1: products
  logic v1;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid;
    end
    if (ce) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
    end
  end

  // stage 2: atan2 operands, pitch sine clamped
  logic v2;
  ops_t o2;
  logic signed [TW-1:0] t2_raw;
  assign t2_raw = (TW'(p_wy) - TW'(p_zx)) <<< 1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v1;
    end
    if (ce) begin
      o2.t0 <= (TW'(p_wx) + TW'(p_yz)) <<< 1;
      o2.t1 <= ONE_T - ((TW'(p_xx) + TW'(p_yy)) <<< 1);
      o2.t3 <= (TW'(p_wz) + TW'(p_xy)) <<< 1;
      o2.t4 <= ONE_T - ((TW'(p_yy) + TW'(p_zz)) <<< 1);
      if (t2_raw > ONE_T) begin
        o2.t2 <= ONE_T;
      end else if (t2_raw < -ONE_T) begin
        o2.t2 <= -ONE_T;
      end else begin
        o2.t2 <= t2_raw;
      end
    end
  end

  // stage 3: 1 - t2^2 for the pitch cosine
  logic v3;
  ops_t o3;
  logic [N_BITS-1:0] n3;
  logic signed [63:0] sq;
  logic [63:0] ndiff;
  assign sq = $signed(o2.t2[31:0]) * $signed(o2.t2[31:0]);
  assign ndiff = ONE_SQ - 64'(sq);
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ce) begin
      v3 <= v2;
    end
    if (ce) begin
      o3 <= o2;
      n3 <= ndiff[N_BITS-1:0];
    end
  end

  logic sq_vld;
  logic [ROOT_BITS-1:0] root;
  qte_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .ce      (ce),
    .in_vld  (v3),
    .n       (n3),
    .out_vld (sq_vld),
    .root    (root)
  );

  ops_t dly [0:ROOT_BITS];
  assign dly[0] = o3;
  for (genvar d = 0; d < ROOT_BITS; d++) begin : g_dly
    always_ff @(posedge clk) begin
      if (ce) begin
        dly[d+1] <= dly[d];
      end
    end
  end

  logic vr, vp, vy;
  logic [15:0] roll_a, pitch_a, yaw_a;
  logic signed [15:0] pitch_s, pitch_c;

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk (clk), .rst (rst), .ce (ce), .in_vld (sq_vld),
    .y (dly[ROOT_BITS].t0), .x (dly[ROOT_BITS].t1),
    .out_vld (vr), .angle (roll_a)
  );
  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk (clk), .rst (rst), .ce (ce), .in_vld (sq_vld),
    .y (dly[ROOT_BITS].t2), .x (TW'(root)),
    .out_vld (vp), .angle (pitch_a)
  );
  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk (clk), .rst (rst), .ce (ce), .in_vld (sq_vld),
    .y (dly[ROOT_BITS].t3), .x (dly[ROOT_BITS].t4),
    .out_vld (vy), .angle (yaw_a)
  );

  assign pitch_s = pitch_a;
  always_comb begin
    if (pitch_s > 16'sd16384) begin
      pitch_c = 16'sd16384;
    end else if (pitch_s < -16'sd16384) begin
      pitch_c = -16'sd16384;
    end else begin
      pitch_c = pitch_s;
    end
  end

  assign last_vld = vr;
  assign out_ld = !m_tvalid || m_tready;
  assign ce = !(last_vld && !out_ld);
  assign s_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ld) begin
      m_tvalid <= last_vld;
    end
    if (out_ld) begin
      m_tdata <= {roll_a, pitch_c, yaw_a};
    end
  end

`include "quaternion_to_euler_assert.svh"

  `QTE_ASSERT_SAME(a_lanes_aligned, clk, rst, 1'b1,
    (vr == vp) && (vr == vy), "CORDIC lanes out of step")
  `QTE_ASSERT_SAME(a_pitch_range, clk, rst, m_tvalid,
    ($signed(m_tdata[31:16]) <= 16'sd16384) && ($signed(m_tdata[31:16]) >= -16'sd16384),
    "pitch out of range")
  `QTE_ASSERT_NEXT(a_stall_hold, clk, rst, last_vld && m_tvalid && !m_tready,
    last_vld && m_tvalid, "result dropped during stall")
endmodule

[hw/rtl/qte_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on qte_pkg.
module qte_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ce,
  input  logic                          in_vld,
  input  logic [qte_pkg::N_BITS-1:0]    n,
  output logic                          out_vld,
  output logic [qte_pkg::ROOT_BITS-1:0] root
);
  import qte_pkg::*;

  logic [N_BITS-1:0]    rem [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] res [0:ROOT_BITS];
  logic                 vld [0:ROOT_BITS];

  assign rem[0] = n;
  assign res[0] = '0;
  assign vld[0] = in_vld;

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_stage
    localparam int K = ROOT_BITS - 1 - g;
    logic [62:0] trial;
    logic        take;
    assign trial = (63'(res[g]) << (K + 1)) + (63'(1) << (2 * K));
    assign take = 63'(rem[g]) >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (ce) begin
        vld[g+1] <= vld[g];
      end
      if (ce) begin
        rem[g+1] <= take ? rem[g] - trial[N_BITS-1:0] : rem[g];
        res[g+1] <= take ? res[g] | (ROOT_BITS'(1) << K) : res[g];
      end
    end
  end

  assign out_vld = vld[ROOT_BITS];
  assign root = res[ROOT_BITS];
endmodule

[hw/rtl/qte_cordic.sv]
// Pipelined vectoring CORDIC giving atan2(y, x) as a 16-bit binary angle.
// Depends on qte_pkg.
module qte_cordic #(
  parameter int STAGES = qte_pkg::DEF_CORDIC_STAGES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ce,
  input  logic                          in_vld,
  input  logic signed [qte_pkg::TW-1:0] y,
  input  logic signed [qte_pkg::TW-1:0] x,
  output logic                          out_vld,
  output logic [15:0]                   angle
);
  import qte_pkg::*;

  logic signed [CW-1:0] xr  [0:STAGES];
  logic signed [CW-1:0] yr  [0:STAGES];
  logic [31:0]          acc [0:STAGES];
  logic                 zr  [0:STAGES];
  logic                 vld [0:STAGES];
  logic [31:0]          rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_vld;
    end
    if (ce) begin
      xr[0]  <= x[TW-1] ? -CW'(x) : CW'(x);
      yr[0]  <= x[TW-1] ? -CW'(y) : CW'(y);
      acc[0] <= x[TW-1] ? PI_BAM : '0;
      zr[0]  <= (x == '0) && (y == '0);
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CW-1:0] xs, ys;
    logic                 pos;
    assign xs = xr[i] >>> i;
    assign ys = yr[i] >>> i;
    assign pos = !yr[i][CW-1] && (yr[i] != '0);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (ce) begin
        vld[i+1] <= vld[i];
      end
      if (ce) begin
        xr[i+1]  <= pos ? xr[i] + ys : xr[i] - ys;
        yr[i+1]  <= pos ? yr[i] - xs : yr[i] + xs;
        acc[i+1] <= pos ? acc[i] + ATAN_TAB[i] : acc[i] - ATAN_TAB[i];
        zr[i+1]  <= zr[i];
      end
    end
  end

  assign rnd = acc[STAGES] + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (ce) begin
      out_vld <= vld[STAGES];
    end
    if (ce) begin
      angle <= zr[STAGES] ? 16'h0000 : rnd[31:16];
    end
  end
endmodule
